// File: src/jce_pkg.sv
package jce_pkg;

  localparam int unsigned PktBytes      = 5;
  localparam int unsigned PktW          = 8 * PktBytes;
  localparam int unsigned CntW          = 3;
  localparam int unsigned QueueDepthDef = 2;

  // TAP states, ARM numbering
  localparam logic [3:0] ST_DRSHIFT = 4'd2;
  localparam logic [3:0] ST_DRPAUSE = 4'd3;
  localparam logic [3:0] ST_IRSHIFT = 4'd10;
  localparam logic [3:0] ST_IRPAUSE = 4'd11;
  localparam logic [3:0] ST_IDLE    = 4'd12;
  localparam logic [3:0] ST_RESET   = 4'd15;

  localparam logic [7:0] BYTE_TRST_ON  = 8'h03;
  localparam logic [7:0] BYTE_TRST_OFF = 8'h54;
  localparam logic [3:0] OP_MOVE       = 4'h1;
  localparam logic [3:0] OP_SCAN       = 4'h6;
  localparam logic [3:0] OP_RUN        = 4'h7;

  typedef enum logic [1:0] {
    REQ_RESET = 2'd0,
    REQ_MOVE  = 2'd1,
    REQ_SCAN  = 2'd2,
    REQ_RUN   = 2'd3
  } req_e;

  // One request's byte list, first byte in the top byte lane.
  typedef struct packed {
    logic [PktW-1:0] bytes;
    logic [CntW-1:0] cnt;
  } pkt_t;

  function automatic logic [3:0] adapter_code(input logic [3:0] st);
    logic [3:0] c;
    case (st)
      4'd0:    c = 4'd7;
      4'd1:    c = 4'd5;
      4'd2:    c = 4'd4;
      4'd3:    c = 4'd6;
      4'd4:    c = 4'd9;
      4'd5:    c = 4'd8;
      4'd6:    c = 4'd3;
      4'd7:    c = 4'd2;
      4'd8:    c = 4'd14;
      4'd9:    c = 4'd12;
      4'd10:   c = 4'd11;
      4'd11:   c = 4'd13;
      4'd12:   c = 4'd1;
      4'd13:   c = 4'd15;
      4'd14:   c = 4'd10;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] move_byte(input logic [3:0] st);
    return {adapter_code(st), OP_MOVE};
  endfunction

endpackage

// File: src/jce_front.sv
module jce_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic                 trst_assert_i,
  input  logic [3:0]           target_state_i,
  input  logic                 ir_scan_i,
  input  logic                 chunk_first_i,
  input  logic                 chunk_last_i,
  input  logic [3:0]           chunk_bits_i,
  input  logic [7:0]           chunk_data_i,
  input  logic [4:0]           cycle_count_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output jce_pkg::pkt_t        pkt_o
);

  logic [3:0]               cur_q, cur_d;
  logic [jce_pkg::PktW-1:0] acc;
  logic [jce_pkg::CntW-1:0] n;
  logic [3:0]               shift_st, pause_st;
  logic [2:0]               bits_m1;
  logic [3:0]               cyc_m1;
  logic                     accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign shift_st   = ir_scan_i ? jce_pkg::ST_IRSHIFT : jce_pkg::ST_DRSHIFT;
  assign pause_st   = ir_scan_i ? jce_pkg::ST_IRPAUSE : jce_pkg::ST_DRPAUSE;
  assign bits_m1    = 3'(chunk_bits_i - 4'd1);
  assign cyc_m1     = 4'(cycle_count_i - 5'd1);

  // Bytes are appended at the bottom, then aligned so the first sits on top.
  always_comb begin
    acc   = '0;
    n     = '0;
    cur_d = cur_q;
    case (jce_pkg::req_e'(req_type_i))
      jce_pkg::REQ_RESET: begin
        acc = {acc[jce_pkg::PktW-9:0],
               trst_assert_i ? jce_pkg::BYTE_TRST_ON : jce_pkg::BYTE_TRST_OFF};
        n   = n + 3'd1;
      end
      jce_pkg::REQ_MOVE: begin
        acc   = {acc[jce_pkg::PktW-9:0], jce_pkg::move_byte(target_state_i)};
        n     = n + 3'd1;
        cur_d = target_state_i;
      end
      jce_pkg::REQ_SCAN: begin
        if (chunk_first_i) begin
          acc   = {acc[jce_pkg::PktW-9:0], jce_pkg::move_byte(shift_st)};
          n     = n + 3'd1;
          cur_d = shift_st;
        end
        acc = {acc[jce_pkg::PktW-9:0], bits_m1, chunk_last_i, jce_pkg::OP_SCAN};
        n   = n + 3'd1;
        acc = {acc[jce_pkg::PktW-9:0], chunk_data_i};
        n   = n + 3'd1;
        if (chunk_last_i) begin
          acc = {acc[jce_pkg::PktW-9:0], jce_pkg::move_byte(pause_st)};
          n   = n + 3'd1;
          if (pause_st != target_state_i) begin
            acc = {acc[jce_pkg::PktW-9:0], jce_pkg::move_byte(target_state_i)};
            n   = n + 3'd1;
          end
          cur_d = target_state_i;
        end
      end
      default: begin
        if (cur_q != jce_pkg::ST_IDLE) begin
          acc = {acc[jce_pkg::PktW-9:0], jce_pkg::move_byte(jce_pkg::ST_IDLE)};
          n   = n + 3'd1;
        end
        if (cycle_count_i != 5'd0) begin
          acc = {acc[jce_pkg::PktW-9:0], cyc_m1, jce_pkg::OP_RUN};
          n   = n + 3'd1;
        end
        if (target_state_i != jce_pkg::ST_IDLE) begin
          acc = {acc[jce_pkg::PktW-9:0], jce_pkg::move_byte(target_state_i)};
          n   = n + 3'd1;
        end
        cur_d = target_state_i;
      end
    endcase
  end

  always_comb begin
    pkt_o.cnt = n;
    case (n)
      3'd1:    pkt_o.bytes = acc << 32;
      3'd2:    pkt_o.bytes = acc << 24;
      3'd3:    pkt_o.bytes = acc << 16;
      3'd4:    pkt_o.bytes = acc << 8;
      default: pkt_o.bytes = acc;
    endcase
  end

  // Run test with nothing to do never reaches the queue.
  assign push_o = accept && (n != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q <= jce_pkg::ST_RESET;
    end else if (accept) begin
      cur_q <= cur_d;
    end
  end

endmodule

// File: src/jce_queue.sv
module jce_queue #(
  parameter int unsigned Depth = jce_pkg::QueueDepthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  jce_pkg::pkt_t push_pkt_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output jce_pkg::pkt_t pop_pkt_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  jce_pkg::pkt_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = (cnt_q == CntW'(Depth));
  assign empty_o   = (cnt_q == '0);
  assign pop_pkt_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_pkt_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("queue count out of range");

  a_queued_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (push_pkt_i.cnt != '0) && (push_pkt_i.cnt <= 3'(jce_pkg::PktBytes)))
    else $error("queued request with bad byte count");

endmodule

// File: src/jce_back.sv
module jce_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_empty_i,
  input  jce_pkg::pkt_t q_pkt_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [7:0]    out_byte_o,
  output logic          last_o
);

  logic [jce_pkg::PktW-1:0] bytes_q, bytes_d;
  logic [jce_pkg::CntW-1:0] rem_q, rem_d;
  logic                     valid_q, valid_d;
  logic [7:0]               byte_q, byte_d;
  logic                     last_q, last_d;
  logic                     adv;

  assign adv = !valid_q || out_ready_i;

  always_comb begin
    bytes_d = bytes_q;
    rem_d   = rem_q;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    pop_o   = 1'b0;
    if (adv) begin
      if (rem_q != '0) begin
        byte_d  = bytes_q[jce_pkg::PktW-1 -: 8];
        last_d  = (rem_q == 3'd1);
        bytes_d = bytes_q << 8;
        rem_d   = rem_q - 3'd1;
        valid_d = 1'b1;
      end else if (!q_empty_i) begin
        pop_o   = 1'b1;
        byte_d  = q_pkt_i.bytes[jce_pkg::PktW-1 -: 8];
        last_d  = (q_pkt_i.cnt == 3'd1);
        bytes_d = q_pkt_i.bytes << 8;
        rem_d   = q_pkt_i.cnt - 3'd1;
        valid_d = 1'b1;
      end else begin
        valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q <= bytes_d;
    byte_q  <= byte_d;
    last_q  <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;

  a_rem_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q < 3'(jce_pkg::PktBytes))
    else $error("remaining byte count out of range");

  a_pending_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rem_q != '0) |-> (valid_q && !last_q))
    else $error("bytes pending behind a last byte");

  a_pop_only_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> (rem_q == '0))
    else $error("pop while request still draining");

endmodule

// File: src/jtag_command_byte_encoder_unit.sv
// A request's byte list goes through the request queue and the output byte register to out_*_o.
// Throughput: one output byte per cycle while out_ready_i is high and bytes are queued; a
//   request yields 1 to 5 bytes, the output byte register being the limit; a run test
//   with nothing to send is accepted and yields nothing.
// Reset (rst_ni low, async): queue and output empty, tracked TAP state = test logic reset.
// Request queue depth is QueueDepth requests.
module jtag_command_byte_encoder_unit #(
  parameter int unsigned QueueDepth = jce_pkg::QueueDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [1:0] req_type_i,
  input  logic       trst_assert_i,
  input  logic [3:0] target_state_i,
  input  logic       ir_scan_i,
  input  logic       chunk_first_i,
  input  logic       chunk_last_i,
  input  logic [3:0] chunk_bits_i,
  input  logic [7:0] chunk_data_i,
  input  logic [4:0] cycle_count_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_o
);

  // Front: takes a request, tracks the TAP state, builds its byte list.
  // Queue: holds built byte lists so front and back stall independently.
  // Back: serializes one list to the byte link, one byte per cycle while out_ready_i is high.
  logic          q_full, q_empty, push, pop;
  jce_pkg::pkt_t push_pkt, pop_pkt;

  jce_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .trst_assert_i  (trst_assert_i),
    .target_state_i (target_state_i),
    .ir_scan_i      (ir_scan_i),
    .chunk_first_i  (chunk_first_i),
    .chunk_last_i   (chunk_last_i),
    .chunk_bits_i   (chunk_bits_i),
    .chunk_data_i   (chunk_data_i),
    .cycle_count_i  (cycle_count_i),
    .q_full_i       (q_full),
    .push_o         (push),
    .pkt_o          (push_pkt)
  );

  jce_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_pkt_i (push_pkt),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .pop_pkt_o  (pop_pkt)
  );

  jce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_pkt_i     (pop_pkt),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
